@@ rtl/tlca_pkg.sv @@
// Shared types and constants of the tank level calibrate/average block.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package tlca_pkg;

	localparam int ADC_W  = 12;
	localparam int VOL_W  = 24;
	localparam int LIT_W  = 17;
	localparam int ERR_W  = 3;

	// divider: dividend holds sample * litre span, divisor holds an ADC span
	localparam int DIVD_W = ADC_W + VOL_W;
	localparam int DIVR_W = 12;
	localparam int CNT_W  = $clog2(DIVD_W + 1);
	localparam int VAL_W  = DIVD_W + 2;

	localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
	localparam logic [ERR_W-1:0] ERR_LIMIT     = 3'd1;
	localparam logic [ERR_W-1:0] ERR_RANGE     = 3'd2;
	localparam logic [ERR_W-1:0] ERR_ZERO_SPAN = 3'd3;
	localparam logic [ERR_W-1:0] ERR_NOT_POS   = 3'd4;

	localparam logic signed [LIT_W-1:0] LITRES_INVALID = -17'sd1;
	localparam logic signed [LIT_W-1:0] LITRES_SAT_MAX = 17'sd65535;

	localparam int REG_AW = 4;
	localparam logic [1:0] REG_ADC_EMPTY = 2'd0;
	localparam logic [1:0] REG_ADC_FULL  = 2'd1;
	localparam logic [1:0] REG_VOL_MIN   = 2'd2;
	localparam logic [1:0] REG_VOL_MAX   = 2'd3;

	// reciprocal m with floor(x / d) == (x * m) >> (n + clog2(d)) for every n-bit x;
	// m fits in n + 1 bits
	function automatic longint unsigned recip_mult(input int n, input int d);
		int k;
		k = n + $clog2(d);
		return ((64'd1 << k) + 64'(d) - 64'd1) / 64'(d);
	endfunction

	typedef struct packed {
		logic [ADC_W-1:0] adc_empty;
		logic [ADC_W-1:0] adc_full;
		logic [VOL_W-1:0] volume_min_ml;
		logic [VOL_W-1:0] volume_max_ml;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;   // left-aligned: the top nbits are the value
		logic [DIVR_W-1:0] divisor;
		logic [CNT_W-1:0]  nbits;
	} div_req_t;

	typedef struct packed {
		logic signed [LIT_W-1:0] litres;
		logic [ADC_W-1:0]        sample;
	} ring_entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SPAN,
		S_PROD,
		S_Q_GO,
		S_Q_WAIT,
		S_CALC,
		S_WRITE,
		S_AVG,
		S_OUT
	} state_t;

endpackage

`default_nettype wire

@@ rtl/tank_level_calibrate_average_core.sv @@
// Tank level calibration and averaging core. Each input beat carries one
// level-sensor ADC sample; the core converts it to whole litres by an
// inverted two-point calibration, stores sample and litres together in one
// ring of RING_DEPTH entries, and returns one output beat with the litres,
// an error code, the truncated ring averages and the empty flag. One sample
// is worked on at a time. A valid sample is paced by the bit-serial divider
// that divides the sample-times-litre-span product by the ADC span one bit
// per cycle; the divisions by ML_PER_LITRE and RING_DEPTH are reciprocal
// multiplications. A rejected sample skips the calibration. A result still
// waiting on the output holds the core in its last state. The ring keeps
// running sums updated by read-modify-write of the slot being replaced, so
// no walk over the ring is needed. The next sample is taken while the
// previous result still waits on the output. No clearing pass: ring slots
// carry valid bits that reset clears. Depends on tlca_pkg, tlca_cfg,
// tlca_ring and tlca_div.
`default_nettype none

module tank_level_calibrate_average_core #(
	parameter int RING_DEPTH   = 10,
	parameter int ADC_LIMIT    = 4095,
	parameter int ML_PER_LITRE = 1000
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [tlca_pkg::REG_AW-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [15:0]                 s_tdata,  // [11:0] adc_sample
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// [16:0] sample_litres, [19:17] error_code, [36:20] average_litres,
	// [48:37] average_adc, [49] tank_empty
	output logic [55:0]                      m_tdata
);
	import tlca_pkg::*;

	localparam int AW     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int LSUM_W = LIT_W + $clog2(RING_DEPTH);
	localparam int ASUM_W = ADC_W + $clog2(RING_DEPTH);

	localparam int               ML_SH  = VOL_W + $clog2(ML_PER_LITRE);
	localparam logic [VOL_W:0]   ML_RCP = (VOL_W+1)'(recip_mult(VOL_W, ML_PER_LITRE));
	localparam int               LA_SH  = LSUM_W + $clog2(RING_DEPTH);
	localparam logic [LSUM_W:0]  LA_RCP = (LSUM_W+1)'(recip_mult(LSUM_W, RING_DEPTH));
	localparam int               AA_SH  = ASUM_W + $clog2(RING_DEPTH);
	localparam logic [ASUM_W:0]  AA_RCP = (ASUM_W+1)'(recip_mult(ASUM_W, RING_DEPTH));

	cfg_t        cfg;
	state_t      state_q, state_d;
	div_req_t    div_req;
	logic        div_done;
	logic [DIVD_W-1:0] quot;

	logic        ring_rd_en, ring_wr_en;
	ring_entry_t ring_old, ring_new;
	logic [AW-1:0] slot_q;

	logic [ADC_W-1:0]  sample_in;
	logic [ERR_W-1:0]  err_in;
	logic              accept;

	logic [ADC_W-1:0]  sample_q;
	logic [ERR_W-1:0]  err_q;
	logic              empty_q;
	logic [VOL_W-1:0]  l_q, b_q;
	logic [DIVD_W-1:0] prod_q;
	logic signed [LIT_W-1:0] lit_q;
	logic signed [LSUM_W-1:0] lsum_q;
	logic [ASUM_W-1:0] asum_q;
	logic signed [LIT_W-1:0] avg_l_q;
	logic [ADC_W-1:0]  avg_a_q;

	logic              out_valid_q;
	logic [55:0]       out_data_q;

	logic [ADC_W-1:0]  adc_span;
	logic [VOL_W-1:0]  vol_span;
	logic signed [VAL_W-1:0] value;
	logic              lsum_neg;
	logic [LSUM_W-1:0] lsum_abs;
	logic signed [LIT_W-1:0] quot_lit;

	logic [2*VOL_W:0]  vspan_prod;
	logic [2*VOL_W:0]  vmin_prod;
	logic [2*LSUM_W:0] lsum_prod;
	logic [2*ASUM_W:0] asum_prod;

	tlca_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tlca_ring #(
		.DEPTH (RING_DEPTH),
		.AW    (AW)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (ring_rd_en),
		.rd_addr (slot_q),
		.rd_data (ring_old),
		.wr_en   (ring_wr_en),
		.wr_addr (slot_q),
		.wr_data (ring_new)
	);

	tlca_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (quot)
	);

	assign sample_in = s_tdata[ADC_W-1:0];
	assign accept    = s_tvalid & s_tready;

	assign adc_span = (cfg.adc_empty >= cfg.adc_full) ? cfg.adc_empty - cfg.adc_full
	                                                  : cfg.adc_full - cfg.adc_empty;
	assign vol_span = (cfg.volume_max_ml >= cfg.volume_min_ml)
	                ? cfg.volume_max_ml - cfg.volume_min_ml
	                : cfg.volume_min_ml - cfg.volume_max_ml;

	// sample checks in priority order
	always_comb begin
		if ({4'b0, sample_in} >= 16'(ADC_LIMIT)) begin
			err_in = ERR_LIMIT;
		end else if (sample_in > cfg.adc_empty || sample_in < cfg.adc_full) begin
			err_in = ERR_RANGE;
		end else if (cfg.adc_empty == cfg.adc_full) begin
			err_in = ERR_ZERO_SPAN;
		end else begin
			err_in = ERR_NONE;
		end
	end

	// constant divisions as multiply by reciprocal, quotient in the top bits
	assign vspan_prod = (2*VOL_W+1)'(vol_span) * (2*VOL_W+1)'(ML_RCP);
	assign vmin_prod  = (2*VOL_W+1)'(cfg.volume_min_ml) * (2*VOL_W+1)'(ML_RCP);
	assign lsum_prod  = (2*LSUM_W+1)'(lsum_abs) * (2*LSUM_W+1)'(LA_RCP);
	assign asum_prod  = (2*ASUM_W+1)'(asum_q) * (2*ASUM_W+1)'(AA_RCP);

	assign value = VAL_W'(l_q) + VAL_W'(b_q) - VAL_W'(quot);
	assign lsum_neg = lsum_q[LSUM_W-1];
	assign lsum_abs = lsum_neg ? LSUM_W'(-lsum_q) : LSUM_W'(lsum_q);
	assign quot_lit = LIT_W'(lsum_prod[2*LSUM_W:LA_SH]);

	assign ring_new.litres = lit_q;
	assign ring_new.sample = sample_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:    if (s_tvalid) state_d = (err_in != ERR_NONE) ? S_CALC : S_SPAN;
			S_SPAN:    state_d = S_PROD;
			S_PROD:    state_d = S_Q_GO;
			S_Q_GO:    state_d = S_Q_WAIT;
			S_Q_WAIT:  if (div_done) state_d = S_CALC;
			S_CALC:    state_d = S_WRITE;
			S_WRITE:   state_d = S_AVG;
			S_AVG:     state_d = S_OUT;
			S_OUT:     if (!out_valid_q || m_tready) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		s_tready     = 1'b0;
		ring_rd_en   = 1'b0;
		ring_wr_en   = 1'b0;
		div_req      = '0;
		unique case (state_q)
			S_IDLE: begin
				s_tready   = 1'b1;
				ring_rd_en = s_tvalid;   // fetch the slot about to be replaced
			end
			S_Q_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = prod_q;
				div_req.divisor  = adc_span;
				div_req.nbits    = CNT_W'(DIVD_W);
			end
			S_WRITE: begin
				ring_wr_en = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			slot_q      <= '0;
			lsum_q      <= '0;
			asum_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_WRITE) begin
				lsum_q <= lsum_q - LSUM_W'(ring_old.litres) + LSUM_W'(lit_q);
				asum_q <= asum_q - ASUM_W'(ring_old.sample) + ASUM_W'(sample_q);
				slot_q <= (slot_q == AW'(RING_DEPTH - 1)) ? '0 : slot_q + 1'b1;
			end
			if (state_q == S_OUT && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample_in;
			err_q    <= err_in;
			empty_q  <= sample_in > cfg.adc_empty;
		end
		if (state_q == S_SPAN) begin
			l_q <= VOL_W'(vspan_prod[2*VOL_W:ML_SH]);
			b_q <= VOL_W'(vmin_prod[2*VOL_W:ML_SH]);
		end
		if (state_q == S_PROD) begin
			prod_q <= DIVD_W'(sample_q) * DIVD_W'(l_q);
		end
		if (state_q == S_CALC) begin
			if (err_q != ERR_NONE) begin
				lit_q <= LITRES_INVALID;
			end else if (value <= 0) begin
				lit_q <= LITRES_INVALID;
				err_q <= ERR_NOT_POS;
			end else if (value > VAL_W'(LITRES_SAT_MAX)) begin
				lit_q <= LITRES_SAT_MAX;
			end else begin
				lit_q <= value[LIT_W-1:0];
			end
		end
		if (state_q == S_AVG) begin
			avg_l_q <= lsum_neg ? -quot_lit : quot_lit;
			avg_a_q <= ADC_W'(asum_prod[2*ASUM_W:AA_SH]);
		end
		if (state_q == S_OUT && (!out_valid_q || m_tready)) begin
			out_data_q <= {6'b0, empty_q, avg_a_q, avg_l_q, err_q, lit_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

@@ rtl/tlca_cfg.sv @@
// APB-style register file for the calibration points and tank volumes.
// Depends on tlca_pkg (cfg_t, register index codes).
`default_nettype none

module tlca_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [tlca_pkg::REG_AW-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	output tlca_pkg::cfg_t                   cfg
);
	import tlca_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[3:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.adc_empty     <= 12'd4095;
			cfg_q.adc_full      <= '0;
			cfg_q.volume_min_ml <= '0;
			cfg_q.volume_max_ml <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_ADC_EMPTY: cfg_q.adc_empty     <= pwdata[ADC_W-1:0];
				REG_ADC_FULL:  cfg_q.adc_full      <= pwdata[ADC_W-1:0];
				REG_VOL_MIN:   cfg_q.volume_min_ml <= pwdata[VOL_W-1:0];
				REG_VOL_MAX:   cfg_q.volume_max_ml <= pwdata[VOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ADC_EMPTY: prdata = 32'(cfg_q.adc_empty);
			REG_ADC_FULL:  prdata = 32'(cfg_q.adc_full);
			REG_VOL_MIN:   prdata = 32'(cfg_q.volume_min_ml);
			REG_VOL_MAX:   prdata = 32'(cfg_q.volume_max_ml);
			default:       prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/tlca_ring.sv @@
// Ring storage of past samples and litre values: one synchronous memory,
// registered read, per-entry valid bits so unwritten slots read zero.
// Depends on tlca_pkg (ring_entry_t).
`default_nettype none

module tlca_ring #(
	parameter int DEPTH = 10,
	parameter int AW    = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  rd_en,
	input  wire logic [AW-1:0]         rd_addr,
	output tlca_pkg::ring_entry_t      rd_data,
	input  wire logic                  wr_en,
	input  wire logic [AW-1:0]         wr_addr,
	input  tlca_pkg::ring_entry_t      wr_data
);
	import tlca_pkg::*;

	ring_entry_t            mem [DEPTH];
	logic [DEPTH-1:0]       valid_q;
	ring_entry_t            rd_data_q;
	logic                   rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		// hold the read word until the next read
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

@@ rtl/tlca_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle, for the division
// by the ADC span. Depends on tlca_pkg (div_req_t, widths).
`default_nettype none

module tlca_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  tlca_pkg::div_req_t               req,
	output logic                             done,
	output logic [tlca_pkg::DIVD_W-1:0]      quot
);
	import tlca_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIVD_W-1:0] dq_q;
	logic [DIVR_W-1:0] rem_q;
	logic [DIVR_W-1:0] divisor_q;

	logic [DIVR_W:0]   trial;
	logic              ge;
	logic [DIVR_W:0]   diff;

	// dividend bits leave at the top, quotient bits enter at the bottom
	assign trial = {rem_q, dq_q[DIVD_W-1]};
	assign ge    = trial >= {1'b0, divisor_q};
	assign diff  = trial - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q      <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[DIVD_W-2:0], ge};
			rem_q <= ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = dq_q;

endmodule

`default_nettype wire
